FILE: rtl/skrs_pkg.sv
`timescale 1ns / 1ps

package skrs_pkg;

    localparam int KEY_W      = 32;
    localparam int BOUND_W    = 13;
    localparam int COUNT_W    = 13;
    localparam int SHIFT_W    = 5;
    localparam int LOAD_IDX_W = 12;
    localparam int LOAD_SPAN  = 4096;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_SHIFT   = 1'b1;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_CMP,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        PH_MAIN,
        PH_LOW,
        PH_HIGH
    } phase_t;

endpackage

FILE: rtl/shifted_key_range_search_top.sv
`timescale 1ns / 1ps
// load transfer: writes a table entry, no result; query: one result per transfer
// a table probe is a memory read (ST_ISSUE), then a compare (ST_CMP); up to three
// binary searches (main, low, high) of ceil(log2(n+1)) probes each, n = entry count
// one query at a time; in_ready is low until the result enters the output register
// reset clears state, config, found flags and out_valid; table contents are kept

module shifted_key_range_search_top #(
    parameter int TABLE_DEPTH = 4096
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 kind,
    input  logic [skrs_pkg::LOAD_IDX_W-1:0]      entry_index,
    input  logic [skrs_pkg::KEY_W-1:0]           entry_value,
    input  logic [skrs_pkg::KEY_W-1:0]           search_key,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 found,
    output logic signed [skrs_pkg::BOUND_W-1:0]  range_low,
    output logic signed [skrs_pkg::BOUND_W-1:0]  range_high,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [skrs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [skrs_pkg::CFG_DATA_W-1:0]      cfg_data
);

    import skrs_pkg::*;

    localparam int AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int IW  = (AW + 2 > 14) ? AW + 2 : 14;
    localparam int CAP = (TABLE_DEPTH < LOAD_SPAN) ? TABLE_DEPTH : LOAD_SPAN;

    logic [KEY_W-1:0] mem [0:TABLE_DEPTH-1];
    logic [KEY_W-1:0] rd_data_reg;
    logic [AW-1:0]    rd_addr;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;

    logic [COUNT_W-1:0] entry_count_reg;
    logic [SHIFT_W-1:0] key_shift_reg;

    logic signed [IW-1:0] l_reg, l_next;
    logic signed [IW-1:0] r_reg, r_next;
    logic signed [IW-1:0] rmain_reg, rmain_next;
    logic signed [IW-1:0] hit_reg, hit_next;
    logic signed [IW-1:0] m_reg, m_next;
    logic [KEY_W-1:0]     key_reg, key_next;
    logic                 res_found_reg, res_found_next;
    logic signed [BOUND_W-1:0] res_lo_reg, res_lo_next;
    logic signed [BOUND_W-1:0] res_hi_reg, res_hi_next;

    logic                      out_valid_reg, out_valid_next;
    logic                      out_found_reg, out_found_next;
    logic signed [BOUND_W-1:0] out_lo_reg, out_lo_next;
    logic signed [BOUND_W-1:0] out_hi_reg, out_hi_next;

    logic                 in_xfer;
    logic                 load_xfer;
    logic                 query_xfer;
    logic                 out_free;
    logic                 win_open;
    logic signed [IW-1:0] m_calc;
    logic signed [IW-1:0] count_ext;
    logic signed [IW-1:0] eff_count;
    logic [IW-1:0]        load_idx_ext;
    logic [KEY_W-1:0]     probe_val;
    logic                 probe_eq;
    logic                 probe_gt;

    assign in_ready   = (state_reg == ST_IDLE);
    assign cfg_ready  = 1'b1;
    assign in_xfer    = in_valid && in_ready;
    assign load_xfer  = in_xfer && (kind == KIND_LOAD);
    assign query_xfer = in_xfer && (kind == KIND_QUERY);
    assign out_free   = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign found      = out_found_reg;
    assign range_low  = out_lo_reg;
    assign range_high = out_hi_reg;

    assign count_ext    = {{(IW - COUNT_W){1'b0}}, entry_count_reg};
    assign eff_count    = (count_ext > IW'(CAP)) ? IW'(CAP) : count_ext;
    assign load_idx_ext = {{(IW - LOAD_IDX_W){1'b0}}, entry_index};
    assign win_open     = (l_reg <= r_reg);
    assign m_calc       = (l_reg + r_reg) >>> 1;
    assign rd_addr      = m_calc[AW-1:0];
    assign probe_val    = rd_data_reg >> key_shift_reg;
    assign probe_eq     = (probe_val == key_reg);
    assign probe_gt     = (probe_val > key_reg);

    // table memory
    always_ff @(posedge clk)
    begin
        if (load_xfer && (load_idx_ext < IW'(TABLE_DEPTH)))
        begin
            mem[load_idx_ext[AW-1:0]] <= entry_value;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
            key_shift_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_ENTRY_COUNT: entry_count_reg <= cfg_data[COUNT_W-1:0];
                CFG_KEY_SHIFT:   key_shift_reg   <= cfg_data[SHIFT_W-1:0];
                default:         ;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (query_xfer)
                begin
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                if (win_open)
                begin
                    state_next = ST_CMP;
                end
                else if (phase_reg != PH_LOW)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_CMP:
            begin
                if ((phase_reg == PH_MAIN) && probe_eq && (key_shift_reg == '0))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_ISSUE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // search datapath and result staging
    always_comb
    begin
        phase_next     = phase_reg;
        l_next         = l_reg;
        r_next         = r_reg;
        rmain_next     = rmain_reg;
        hit_next       = hit_reg;
        m_next         = m_reg;
        key_next       = key_reg;
        res_found_next = res_found_reg;
        res_lo_next    = res_lo_reg;
        res_hi_next    = res_hi_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_found_next = out_found_reg;
        out_lo_next    = out_lo_reg;
        out_hi_next    = out_hi_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (query_xfer)
                begin
                    phase_next     = PH_MAIN;
                    l_next         = '0;
                    r_next         = eff_count - IW'(1);
                    key_next       = search_key;
                    res_found_next = 1'b0;
                    res_lo_next    = '1;
                    res_hi_next    = '1;
                end
            end
            ST_ISSUE:
            begin
                if (win_open)
                begin
                    m_next = m_calc;
                end
                else if (phase_reg == PH_LOW)
                begin
                    phase_next = PH_HIGH;
                    l_next     = hit_reg + IW'(1);
                    r_next     = rmain_reg;
                end
            end
            ST_CMP:
            begin
                if (probe_eq)
                begin
                    case (phase_reg)
                        PH_MAIN:
                        begin
                            res_found_next = 1'b1;
                            res_lo_next    = m_reg[BOUND_W-1:0];
                            res_hi_next    = m_reg[BOUND_W-1:0];
                            hit_next       = m_reg;
                            rmain_next     = r_reg;
                            phase_next     = PH_LOW;
                            r_next         = m_reg - IW'(1);
                        end
                        PH_LOW:
                        begin
                            res_lo_next = m_reg[BOUND_W-1:0];
                            r_next      = m_reg - IW'(1);
                        end
                        default:
                        begin
                            res_hi_next = m_reg[BOUND_W-1:0];
                            l_next      = m_reg + IW'(1);
                        end
                    endcase
                end
                else if (probe_gt)
                begin
                    r_next = m_reg - IW'(1);
                end
                else
                begin
                    l_next = m_reg + IW'(1);
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_found_next = res_found_reg;
                    out_lo_next    = res_lo_reg;
                    out_hi_next    = res_hi_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_MAIN;
            out_valid_reg <= 1'b0;
            res_found_reg <= 1'b0;
            out_found_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
            res_found_reg <= res_found_next;
            out_found_reg <= out_found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        l_reg      <= l_next;
        r_reg      <= r_next;
        rmain_reg  <= rmain_next;
        hit_reg    <= hit_next;
        m_reg      <= m_next;
        key_reg    <= key_next;
        res_lo_reg <= res_lo_next;
        res_hi_reg <= res_hi_next;
        out_lo_reg <= out_lo_next;
        out_hi_reg <= out_hi_next;
    end

    a_found_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && found |-> !range_low[BOUND_W-1] && (range_low <= range_high))
        else $error("found result with bad bounds");

    a_miss_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> (range_low == '1) && (range_high == '1))
        else $error("miss result with bounds other than -1");

    a_exact_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && found && (key_shift_reg == '0) |-> range_low == range_high)
        else $error("exact mode gave a range");

    a_cmp_after_issue: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CMP |-> $past(state_reg) == ST_ISSUE)
        else $error("compare without a memory read");

endmodule
